>>> hw/rtl/pslm_pkg.sv
// shared types, constants and helpers of the per-flow sequence loss monitor
package pslm_pkg;

   // field widths fixed by the message and result formats
   localparam int FLOW_INDEX_W = 4;
   localparam int FLOW_SPAN    = 1 << FLOW_INDEX_W;
   localparam int SEQ_W        = 32;
   localparam int TIME_W       = 48;
   localparam int LATENCY_W    = TIME_W + 1;
   localparam int COUNT_W      = 32;
   localparam int RCV_W        = 31;

   // default number of tracked flows
   localparam int FLOW_COUNT_DEFAULT = 16;

   // saturation limit of the received counter
   localparam logic [RCV_W-1:0] RCV_MAX = {RCV_W{1'b1}};

   // loss figure: gaps * 10000 / expected, 45-bit magnitude divided bit-serially
   localparam int LOSS_SCALE_W = 15;
   localparam logic signed [LOSS_SCALE_W-1:0] LOSS_SCALE = 15'sd10000;
   localparam int PROD_W    = COUNT_W + LOSS_SCALE_W;
   localparam int MAG_W     = 45;
   localparam int DIV_STEPS = MAG_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one received message
   typedef struct packed {
      logic [FLOW_INDEX_W-1:0] flow_index;
      logic [SEQ_W-1:0]        sequence_number;
      logic [TIME_W-1:0]       send_time_ms;
      logic [TIME_W-1:0]       receive_time_ms;
   } req_item_type;

   // classified item handed from front to back
   typedef struct packed {
      logic signed [LATENCY_W-1:0] latency_ms;
      logic signed [COUNT_W-1:0]   gap_found;
      logic [RCV_W-1:0]            rcv_sum;
      logic signed [COUNT_W-1:0]   exp_sum;
      logic signed [COUNT_W-1:0]   gap_sum;
   } mid_item_type;

   // one result
   typedef struct packed {
      logic signed [LATENCY_W-1:0] latency_ms;
      logic signed [COUNT_W-1:0]   gap_found;
      logic [RCV_W-1:0]            rcv_sum;
      logic signed [COUNT_W-1:0]   exp_sum;
      logic signed [COUNT_W-1:0]   gap_sum;
      logic signed [COUNT_W-1:0]   loss_hundredths_percent;
   } rsp_item_type;

   // saturating increment of a received counter
   function automatic logic [RCV_W-1:0] sat_inc(input logic [RCV_W-1:0] value);
      logic [RCV_W-1:0] result;
      begin
         result = (value == RCV_MAX) ? value : value + RCV_W'(1);
         return result;
      end
   endfunction

endpackage

>>> hw/rtl/pslm_ram.sv
// generic single-port-write, single-port-read ram with registered read
module pslm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/pslm_front.sv
// front: accepts messages, looks up the flow, updates totals, queues the item
module pslm_front #(
   parameter int FLOW_COUNT = pslm_pkg::FLOW_COUNT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  pslm_pkg::req_item_type req_item,
   output logic                  q_push,
   input  logic                  q_full,
   output pslm_pkg::mid_item_type q_data
);

   localparam int ADDR_W = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
   localparam int EXT_W  = (ADDR_W > pslm_pkg::FLOW_INDEX_W) ? ADDR_W : pslm_pkg::FLOW_INDEX_W;

   localparam logic F_IDLE = 1'b0;
   localparam logic F_LOOK = 1'b1;

   logic                              state_ff, state_in;
   pslm_pkg::req_item_type            item_ff, item_in;
   logic                              in_range_ff, in_range_in;
   logic [pslm_pkg::FLOW_SPAN-1:0]    seen_ff, seen_in;
   logic [pslm_pkg::COUNT_W-1:0]      sum_gaps_ff, sum_gaps_in;
   logic [pslm_pkg::COUNT_W-1:0]      sum_exp_ff, sum_exp_in;
   logic [pslm_pkg::RCV_W-1:0]        sum_rcv_ff, sum_rcv_in;

   logic                              accept;
   logic [EXT_W-1:0]                  rd_ext, wr_ext;
   logic [ADDR_W-1:0]                 rd_addr, wr_addr;
   logic [pslm_pkg::SEQ_W-1:0]        last_seq;
   logic [pslm_pkg::COUNT_W-1:0]      step, gap;
   logic                              flow_seen;
   logic                              ram_wr;

   assign full   = (state_ff != F_IDLE);
   assign accept = push && !full;

   // flow table addresses
   assign rd_ext  = EXT_W'(req_item.flow_index);
   assign rd_addr = rd_ext[ADDR_W-1:0];
   assign wr_ext  = EXT_W'(item_ff.flow_index);
   assign wr_addr = wr_ext[ADDR_W-1:0];

   // last sequence number per flow
   pslm_ram #(
      .WIDTH (pslm_pkg::SEQ_W),
      .DEPTH (FLOW_COUNT)
   ) last_seq_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (wr_addr),
      .wr_data (item_ff.sequence_number),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (last_seq)
   );

   // classification of the held item
   assign flow_seen = seen_ff[item_ff.flow_index];
   assign step      = item_ff.sequence_number - last_seq;
   assign gap       = step - pslm_pkg::COUNT_W'(1);
   assign q_push    = (state_ff == F_LOOK) && !q_full;
   assign ram_wr    = q_push && in_range_ff;

   // state and totals
   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      in_range_in = in_range_ff;
      seen_in     = seen_ff;
      sum_gaps_in = sum_gaps_ff;
      sum_exp_in  = sum_exp_ff;
      sum_rcv_in  = sum_rcv_ff;
      case (state_ff)
         F_IDLE: begin
            if (push) begin
               item_in     = req_item;
               in_range_in = (32'(req_item.flow_index) < 32'(FLOW_COUNT));
               state_in    = F_LOOK;
            end
         end
         F_LOOK: begin
            if (!q_full) begin
               state_in = F_IDLE;
               if (in_range_ff) begin
                  sum_rcv_in = pslm_pkg::sat_inc(sum_rcv_ff);
                  seen_in[item_ff.flow_index] = 1'b1;
                  if (flow_seen) begin
                     sum_gaps_in = sum_gaps_ff + gap;
                     sum_exp_in  = sum_exp_ff + step;
                  end else begin
                     sum_exp_in  = sum_exp_ff + pslm_pkg::COUNT_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // item handed to the back
   always_comb begin
      q_data.latency_ms = $signed({1'b0, item_ff.receive_time_ms})
                        - $signed({1'b0, item_ff.send_time_ms});
      q_data.gap_found  = (in_range_ff && flow_seen) ? gap : '0;
      q_data.rcv_sum    = sum_rcv_in;
      q_data.exp_sum    = sum_exp_in;
      q_data.gap_sum    = sum_gaps_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         seen_ff     <= '0;
         sum_gaps_ff <= '0;
         sum_exp_ff  <= '0;
         sum_rcv_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         seen_ff     <= seen_in;
         sum_gaps_ff <= sum_gaps_in;
         sum_exp_ff  <= sum_exp_in;
         sum_rcv_ff  <= sum_rcv_in;
      end
   end

   // held item
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      in_range_ff <= in_range_in;
   end

   // an accepted item is looked up in the next cycle
   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == F_LOOK))
      else $error("accepted item did not move to lookup");

   // a lookup that finds room in the queue frees the front
   a_look_done: assert property (@(posedge clock) disable iff (reset)
      q_push |=> !full)
      else $error("front stayed busy after queuing an item");

   // received total grows only when an in-range item is queued, by one until it saturates
   a_rcv_step: assert property (@(posedge clock) disable iff (reset)
      !(q_push && in_range_ff) |=> $stable(sum_rcv_ff))
      else $error("received total changed without an item");

endmodule

>>> hw/rtl/pslm_fifo.sv
// short queue of classified items between front and back
module pslm_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_push,
   output logic                   q_full,
   input  pslm_pkg::mid_item_type q_wdata,
   input  logic                   q_pop,
   output logic                   q_empty,
   output pslm_pkg::mid_item_type q_rdata
);

   localparam logic [pslm_pkg::QPTR_W-1:0] LAST_SLOT = pslm_pkg::QPTR_W'(pslm_pkg::QUEUE_DEPTH - 1);
   localparam logic [pslm_pkg::QCNT_W-1:0] CNT_FULL  = pslm_pkg::QCNT_W'(pslm_pkg::QUEUE_DEPTH);

   pslm_pkg::mid_item_type           slot_ff [pslm_pkg::QUEUE_DEPTH];
   logic [pslm_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pslm_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pslm_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                             do_push, do_pop;

   assign q_full  = (count_ff == CNT_FULL);
   assign q_empty = (count_ff == '0);
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;
   assign q_rdata = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + pslm_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + pslm_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + pslm_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - pslm_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_wdata;
      end
   end

   // fill level stays within the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");

endmodule

>>> hw/rtl/pslm_back.sv
// back: computes the loss figure with a serial divider and holds the result
module pslm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   output logic                   q_pop,
   input  pslm_pkg::mid_item_type q_rdata,
   output logic                   empty,
   input  logic                   pop,
   output pslm_pkg::rsp_item_type rsp_item
);

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_MUL  = 3'd1;
   localparam logic [2:0] B_PREP = 3'd2;
   localparam logic [2:0] B_DIV  = 3'd3;
   localparam logic [2:0] B_SAT  = 3'd4;
   localparam logic [2:0] B_DONE = 3'd5;

   localparam int W = pslm_pkg::COUNT_W;

   logic [2:0]                          state_ff, state_in;
   pslm_pkg::mid_item_type              entry_ff, entry_in;
   logic signed [pslm_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic                                neg_ff, neg_in;
   logic [pslm_pkg::MAG_W-1:0]          quo_ff, quo_in;
   logic [W-1:0]                        rem_ff, rem_in;
   logic [W-2:0]                        div_ff, div_in;
   logic [pslm_pkg::STEP_W-1:0]         cnt_ff, cnt_in;
   logic [W-1:0]                        loss_ff, loss_in;
   logic                                out_valid_ff, out_valid_in;
   pslm_pkg::rsp_item_type              out_ff, out_in;

   logic [pslm_pkg::PROD_W-1:0]         prod_abs;
   logic [W-1:0]                        trial;
   logic                                fits;
   logic                                out_free;
   logic                                over_neg, over_pos;

   assign empty    = !out_valid_ff;
   assign rsp_item = out_ff;
   assign out_free = !out_valid_ff || pop;
   assign q_pop    = (state_ff == B_IDLE) && !q_empty;

   // divider datapath
   assign prod_abs = prod_ff[pslm_pkg::PROD_W-1] ? pslm_pkg::PROD_W'(-prod_ff)
                                                  : pslm_pkg::PROD_W'(prod_ff);
   assign trial    = {rem_ff[W-2:0], quo_ff[pslm_pkg::MAG_W-1]};
   assign fits     = (trial >= {1'b0, div_ff});

   // saturation of the quotient magnitude
   assign over_neg = (|quo_ff[pslm_pkg::MAG_W-1:W]) || (quo_ff[W-1] && (|quo_ff[W-2:0]));
   assign over_pos = |quo_ff[pslm_pkg::MAG_W-1:W-1];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      entry_in     = entry_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      loss_in      = loss_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !pop;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               entry_in = q_rdata;
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            prod_in  = pslm_pkg::PROD_W'($signed(entry_ff.gap_sum))
                     * pslm_pkg::PROD_W'(pslm_pkg::LOSS_SCALE);
            state_in = B_PREP;
         end
         B_PREP: begin
            neg_in = prod_ff[pslm_pkg::PROD_W-1];
            quo_in = prod_abs[pslm_pkg::MAG_W-1:0];
            rem_in = '0;
            div_in = entry_ff.exp_sum[W-2:0];
            cnt_in = pslm_pkg::STEP_W'(pslm_pkg::DIV_STEPS - 1);
            // expected total not positive gives zero loss
            if ($signed(entry_ff.exp_sum) <= 0) begin
               loss_in  = '0;
               state_in = B_DONE;
            end else begin
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            rem_in = fits ? (trial - {1'b0, div_ff}) : trial;
            quo_in = {quo_ff[pslm_pkg::MAG_W-2:0], fits};
            if (cnt_ff == '0) begin
               state_in = B_SAT;
            end else begin
               cnt_in = cnt_ff - pslm_pkg::STEP_W'(1);
            end
         end
         B_SAT: begin
            if (neg_ff) begin
               loss_in = over_neg ? {1'b1, {(W-1){1'b0}}} : -quo_ff[W-1:0];
            end else begin
               loss_in = over_pos ? {1'b0, {(W-1){1'b1}}} : {1'b0, quo_ff[W-2:0]};
            end
            state_in = B_DONE;
         end
         B_DONE: begin
            if (out_free) begin
               out_in.latency_ms              = entry_ff.latency_ms;
               out_in.gap_found               = entry_ff.gap_found;
               out_in.rcv_sum                 = entry_ff.rcv_sum;
               out_in.exp_sum                 = entry_ff.exp_sum;
               out_in.gap_sum                 = entry_ff.gap_sum;
               out_in.loss_hundredths_percent = loss_ff;
               out_valid_in                   = 1'b1;
               state_in                       = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      cnt_ff   <= cnt_in;
      loss_ff  <= loss_in;
      out_ff   <= out_in;
   end

   // partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (rem_ff < {1'b0, div_ff}))
      else $error("divider remainder out of range");

   // a waiting result is not overwritten
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == B_DONE) && out_valid_ff && !pop) |=> (state_ff == B_DONE))
      else $error("result overwritten before it was taken");

   // the divider only runs on a positive expected total
   a_div_positive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (div_ff != '0))
      else $error("divider started with zero divisor");

endmodule

>>> hw/rtl/per_flow_sequence_loss_monitor.sv
// top level of the per-flow sequence loss monitor
//
//   channel   ports                     handshake
//   request   push, full, req_item      taken when push && !full
//   response  empty, pop, rsp_item      taken when pop && !empty
//
// the front accepts a message, then does its flow table lookup before it takes the next one
// the back computes the loss figure of each item with the 45-step serial divider
// and takes the next item from the queue only once the last result is registered
// a two-entry queue lets the front keep taking messages while the back divides
// reset clears seen flags and totals; the last-sequence table needs no clearing
// full stays high while the front waits on a full queue; a held result waits for pop
module per_flow_sequence_loss_monitor #(
   parameter int FLOW_COUNT = pslm_pkg::FLOW_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  pslm_pkg::req_item_type req_item,
   output logic                   empty,
   input  logic                   pop,
   output pslm_pkg::rsp_item_type rsp_item
);

   logic                   q_push, q_full, q_pop, q_empty;
   pslm_pkg::mid_item_type q_wdata, q_rdata;

   // classification and totals
   pslm_front #(
      .FLOW_COUNT (FLOW_COUNT)
   ) front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_data   (q_wdata)
   );

   // decoupling queue
   pslm_fifo queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_full  (q_full),
      .q_wdata (q_wdata),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_rdata (q_rdata)
   );

   // loss figure and result register
   pslm_back back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .q_rdata  (q_rdata),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule
